[sv/qeo_pkg.sv]
// Shared types, widths and constants for the quadrature encoder odometry block.
package qeo_pkg;

   // Default depth of the velocity moving average
   localparam int unsigned FILTER_TAPS_DEF = 8;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Serial datapath widths
   localparam int unsigned INCR_W  = 56;               // unit increment, always below 2^56
   localparam int unsigned MC_W    = INCR_W;           // multiplicand
   localparam int unsigned MP_W    = 32;               // multiplier bits, one per cycle
   localparam int unsigned PROD_W  = MC_W + MP_W;
   localparam int unsigned NUM_W   = 76;               // dividend shift register
   localparam int unsigned DVS_W   = 48;               // divisor and partial remainder
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned VEL_BITS = 31;              // quotient bits of the velocity divide
   localparam int unsigned POS_W   = INCR_W + 2;       // position sum before saturation
   localparam int unsigned DEN_W   = 22;               // gear * pulses
   localparam int unsigned KMM_W   = 41;               // radius * pi/2 scale

   // Scale constants
   localparam logic [24:0] PI_HALF_Q24  = 25'd26353589;   // pi/2 * 2^24
   localparam logic [22:0] DEG_SCALE    = 23'd5898240;    // 90 * 2^16
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [9:0]  MM_PER_M     = 10'd1000;
   localparam logic [18:0] STARTUP_US   = 19'd500000;
   localparam logic [30:0] VEL_MAX      = 31'h7FFF_FFFF;
   localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN        = 32'h8000_0000;

   // Item opcodes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_WRAP   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COUNTER_RELOAD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GEAR_RATIO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PULSES_PER_REV = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_MM_Q8   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_PERIOD_US = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT_MODE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_COUNT   = 3'd6;

   // Output units
   localparam logic [1:0] UNIT_RAD = 2'd0;
   localparam logic [1:0] UNIT_DEG = 2'd1;
   localparam logic [1:0] UNIT_MM  = 2'd2;
   localparam logic [1:0] UNIT_M   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] counter_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic               direction;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXT,
      ST_MAG,
      ST_MUL1,
      ST_D1LD,
      ST_DIV1,
      ST_POS,
      ST_MUL2,
      ST_VCHK,
      ST_DIV2,
      ST_FILT,
      ST_D3LD,
      ST_DIV3,
      ST_OUT
   } state_type;

endpackage

[sv/quadrature_encoder_odometry.sv]
// Quadrature encoder odometry: wrap extension, unit scaling, position and filtered velocity.
//
// Channel  Dir  Handshake              Beat contents
// req      in   req_valid / req_stall  req_type: op, counter_value
// rsp      out  rsp_valid / rsp_stall  rsp_type: position, velocity, direction
// csr      in   csr_valid / csr_ready  csr_index, csr_wdata
//
// Tick, wrap and unused items are handled in the idle state; an update runs the serial
// datapath and skips the velocity divide when velocity saturates or no time elapsed.
// The datapath has one shift-add multiplier and one restoring divider, both
// one bit per cycle, used in turn for the unit scale, velocity and the average.
// The result register frees the datapath: the next beat is taken while a result waits.
// Reset is synchronous and restores register defaults and clears all tracking state.
module quadrature_encoder_odometry
   import qeo_pkg::*;
#(
   parameter int unsigned FILTER_TAPS = FILTER_TAPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned SUM_W = 32 + $clog2(FILTER_TAPS);

   // Configuration registers
   logic [15:0] reload_ff, reload_in;
   logic [9:0]  gear_ff, gear_in;
   logic [11:0] ppr_ff, ppr_in;
   logic [15:0] radius_ff, radius_in;
   logic [15:0] tperiod_ff, tperiod_in;
   logic [1:0]  unit_ff, unit_in;
   logic        invert_ff, invert_in;

   // Tracking state
   state_type          state_ff, state_in;
   logic [31:0]        tick_ff, tick_in;
   logic [31:0]        last_tick_ff, last_tick_in;
   logic [15:0]        wrap_ff, wrap_in;
   logic [31:0]        last_ext_ff, last_ext_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] hist_ff [FILTER_TAPS];
   logic signed [31:0] hist_in [FILTER_TAPS];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers of one update
   logic [15:0]        cnt_ff, cnt_in;
   logic [31:0]        ext_ff, ext_in;
   logic [DVS_W-1:0]   ts_ff, ts_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [KMM_W-1:0]   kmm_ff, kmm_in;
   logic               neg_ff, neg_in;
   logic [MC_W-1:0]    mc_ff, mc_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               sneg_ff, sneg_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic [31:0]         tmul_a;
   logic [DVS_W-1:0]    tmul;
   logic                wrap_hold;
   logic                wrap_down;
   logic signed [32:0]  wrap_prod;
   logic [31:0]         ext_new;
   logic [9:0]          gear_eff;
   logic [11:0]         ppr_eff;
   logic [DEN_W-1:0]    den_new;
   logic [KMM_W-1:0]    kmm_new;
   logic [31:0]         delta;
   logic [31:0]         mag;
   logic                neg_new;
   logic [MC_W-1:0]     ksel;
   logic [31:0]         den1000;
   logic [MC_W:0]       madd;
   logic [PROD_W-1:0]   mul_next;
   logic [DVS_W:0]      rem_sh;
   logic [DVS_W:0]      rem_diff;
   logic                qbit;
   logic [DVS_W-1:0]    rem_next;
   logic [NUM_W-1:0]    num_next;
   logic [INCR_W-1:0]   div1_num;
   logic [POS_W-1:0]    pos_wide;
   logic [POS_W-1:0]    inc_wide;
   logic [POS_W-1:0]    pos_sum;
   logic                pos_ovf;
   logic [31:0]         pos_sat;
   logic [NUM_W-VEL_BITS-1:0] vnum_hi;
   logic                vsat;
   logic [31:0]         vmag_ext;
   logic signed [31:0]  vraw;
   logic signed [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0]    sum_u;
   logic [SUM_W-1:0]    sum_abs;
   logic [31:0]         vel_q;
   logic [31:0]         vel_out;

   // Time product: elapsed ticks for an update, absolute ticks for a wrap
   assign tmul_a    = (state_ff == ST_IDLE) ? tick_ff : (tick_ff - last_tick_ff);
   assign tmul      = DVS_W'(tmul_a) * DVS_W'(tperiod_ff);
   assign wrap_hold = (tmul <= DVS_W'(STARTUP_US));
   assign wrap_down = ({req_data.counter_value, 1'b0} > {1'b0, reload_ff});

   // Extended count and scale factors
   assign wrap_prod = 33'($signed(wrap_ff)) * 33'($signed({1'b0, reload_ff}));
   assign ext_new   = {16'b0, cnt_ff} + wrap_prod[31:0];
   assign gear_eff  = (gear_ff == 10'd0) ? 10'd1 : gear_ff;
   assign ppr_eff   = (ppr_ff == 12'd0) ? 12'd1 : ppr_ff;
   assign den_new   = DEN_W'(gear_eff) * DEN_W'(ppr_eff);
   assign kmm_new   = KMM_W'(radius_ff) * KMM_W'(PI_HALF_Q24);
   assign den1000   = 32'(den_ff) * 32'(MM_PER_M);

   // Count change, its magnitude and its direction
   assign delta   = ext_ff - last_ext_ff;
   assign mag     = delta[31] ? (~delta + 32'd1) : delta;
   assign neg_new = ((delta != 32'd0) && !delta[31]) != invert_ff;

   always_comb begin
      case (unit_ff)
         UNIT_RAD: ksel = MC_W'(PI_HALF_Q24);
         UNIT_DEG: ksel = MC_W'(DEG_SCALE);
         default:  ksel = MC_W'(kmm_ff);
      endcase
   end

   // Align the scaled count so the divisor needs no fixed shift
   always_comb begin
      case (unit_ff)
         UNIT_RAD: div1_num = prod_ff[INCR_W+7:8];
         UNIT_DEG: div1_num = prod_ff[INCR_W-1:0];
         default:  div1_num = prod_ff[INCR_W+15:16];
      endcase
   end

   // Shift-add multiplier step: add on the low multiplier bit, shift right
   assign madd     = {1'b0, prod_ff[PROD_W-1:MP_W]} + (prod_ff[0] ? {1'b0, mc_ff} : '0);
   assign mul_next = {madd, prod_ff[MP_W-1:1]};

   // Restoring divider step: one quotient bit per cycle
   assign rem_sh   = {rem_ff, num_ff[NUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign qbit     = (rem_sh >= {1'b0, dvs_ff});
   assign rem_next = qbit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
   assign num_next = {num_ff[NUM_W-2:0], qbit};

   // Position accumulate with saturation
   assign pos_wide = {{(POS_W-32){pos_ff[31]}}, pos_ff};
   assign inc_wide = {2'b0, num_ff[INCR_W-1:0]};
   assign pos_sum  = neg_ff ? (pos_wide - inc_wide) : (pos_wide + inc_wide);
   assign pos_ovf  = (pos_sum[POS_W-1:31] != {(POS_W-31){pos_sum[POS_W-1]}});
   assign pos_sat  = pos_ovf ? (pos_sum[POS_W-1] ? Q_MIN : Q_MAX) : pos_sum[31:0];

   // Velocity: quotient fits 31 bits only when the dividend's high part is below the divisor
   assign vnum_hi  = prod_ff[NUM_W-1:VEL_BITS];
   assign vsat     = (DVS_W'(vnum_hi) >= ts_ff);
   assign vmag_ext = {1'b0, num_ff[VEL_BITS-1:0]};
   assign vraw     = neg_ff ? $signed(~vmag_ext + 32'd1) : $signed(vmag_ext);

   // Running sum of the history, then sign and magnitude for the average
   assign sum_new  = sum_ff - SUM_W'(hist_ff[FILTER_TAPS-1]) + SUM_W'(vraw);
   assign sum_u    = sum_ff;
   assign sum_abs  = sum_ff[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
   assign vel_q    = num_ff[31:0];
   assign vel_out  = sneg_ff ? (~vel_q + 32'd1) : vel_q;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      reload_in    = reload_ff;
      gear_in      = gear_ff;
      ppr_in       = ppr_ff;
      radius_in    = radius_ff;
      tperiod_in   = tperiod_ff;
      unit_in      = unit_ff;
      invert_in    = invert_ff;
      tick_in      = tick_ff;
      last_tick_in = last_tick_ff;
      wrap_in      = wrap_ff;
      last_ext_in  = last_ext_ff;
      pos_in       = pos_ff;
      hist_in      = hist_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_in       = cnt_ff;
      ext_in       = ext_ff;
      ts_in        = ts_ff;
      den_in       = den_ff;
      kmm_in       = kmm_ff;
      neg_in       = neg_ff;
      mc_in        = mc_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      step_in      = step_ff;
      sneg_in      = sneg_ff;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;

      // Register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COUNTER_RELOAD: reload_in  = csr_wdata;
            REG_GEAR_RATIO:     gear_in    = csr_wdata[9:0];
            REG_PULSES_PER_REV: ppr_in     = csr_wdata[11:0];
            REG_RADIUS_MM_Q8:   radius_in  = csr_wdata;
            REG_TICK_PERIOD_US: tperiod_in = csr_wdata;
            REG_UNIT_MODE:      unit_in    = csr_wdata[1:0];
            REG_INVERT_COUNT:   invert_in  = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_data.op)
                  OP_TICK: tick_in = tick_ff + 32'd1;
                  OP_WRAP: begin
                     if (wrap_hold) begin
                        wrap_in = '0;
                     end else if (wrap_down) begin
                        wrap_in = wrap_ff - 16'd1;
                     end else begin
                        wrap_in = wrap_ff + 16'd1;
                     end
                  end
                  OP_UPDATE: begin
                     cnt_in   = req_data.counter_value;
                     state_in = ST_EXT;
                  end
                  default: ;
               endcase
            end
         end
         ST_EXT: begin
            ext_in   = ext_new;
            ts_in    = tmul;
            den_in   = den_new;
            kmm_in   = kmm_new;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            neg_in       = neg_new;
            mc_in        = ksel;
            prod_in      = {{MC_W{1'b0}}, mag};
            step_in      = '0;
            dvs_in       = (unit_ff == UNIT_M) ? DVS_W'(den1000) : DVS_W'(den_ff);
            last_ext_in  = ext_ff;
            last_tick_in = tick_ff;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in = mul_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MP_W - 1)) begin
               state_in = ST_D1LD;
            end
         end
         ST_D1LD: begin
            num_in   = {div1_num, {(NUM_W-INCR_W){1'b0}}};
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(INCR_W - 1)) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            pos_in   = $signed(pos_sat);
            mc_in    = num_ff[INCR_W-1:0];
            prod_in  = {{MC_W{1'b0}}, MP_W'(USEC_PER_SEC)};
            step_in  = '0;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in = mul_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MP_W - 1)) begin
               state_in = ST_VCHK;
            end
         end
         ST_VCHK: begin
            rem_in  = DVS_W'(vnum_hi);
            num_in  = {prod_ff[VEL_BITS-1:0], {(NUM_W-VEL_BITS){1'b0}}};
            dvs_in  = ts_ff;
            step_in = '0;
            if (ts_ff == '0) begin
               num_in   = '0;
               state_in = ST_FILT;
            end else if (vsat) begin
               num_in   = NUM_W'(VEL_MAX);
               state_in = ST_FILT;
            end else begin
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VEL_BITS - 1)) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            hist_in[0] = vraw;
            for (int i = 1; i < FILTER_TAPS; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            sum_in   = sum_new;
            state_in = ST_D3LD;
         end
         ST_D3LD: begin
            num_in   = {sum_abs, {(NUM_W-SUM_W){1'b0}}};
            rem_in   = '0;
            dvs_in   = DVS_W'(FILTER_TAPS);
            sneg_in  = sum_ff[SUM_W-1];
            step_in  = '0;
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.position  = pos_ff;
               rsp_data_in.velocity  = $signed(vel_out);
               rsp_data_in.direction = neg_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= 16'd65535;
         gear_ff      <= 10'd30;
         ppr_ff       <= 12'd13;
         radius_ff    <= 16'd8448;
         tperiod_ff   <= 16'd1000;
         unit_ff      <= UNIT_RAD;
         invert_ff    <= 1'b0;
         tick_ff      <= '0;
         last_tick_ff <= '0;
         wrap_ff      <= '0;
         last_ext_ff  <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FILTER_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         reload_ff    <= reload_in;
         gear_ff      <= gear_in;
         ppr_ff       <= ppr_in;
         radius_ff    <= radius_in;
         tperiod_ff   <= tperiod_in;
         unit_ff      <= unit_in;
         invert_ff    <= invert_in;
         tick_ff      <= tick_in;
         last_tick_ff <= last_tick_in;
         wrap_ff      <= wrap_in;
         last_ext_ff  <= last_ext_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < FILTER_TAPS; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      ext_ff      <= ext_in;
      ts_ff       <= ts_in;
      den_ff      <= den_in;
      kmm_ff      <= kmm_in;
      neg_ff      <= neg_in;
      mc_ff       <= mc_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      step_ff     <= step_in;
      sneg_ff     <= sneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Partial remainder stays below the divisor in every divide
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV1 || state_ff == ST_DIV2 || state_ff == ST_DIV3)
         |-> (rem_ff < dvs_ff))
      else $error("divider remainder reached the divisor");

   // A result beat only comes out of the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   // Wraps during the startup window leave the wrap count at zero
   a_wrap_startup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_data.op == OP_WRAP && wrap_hold)
         |=> (wrap_ff == '0))
      else $error("wrap count moved during startup window");
`endif

endmodule

[dv/tb_quadrature_encoder_odometry.sv]
// Self-checking testbench for the quadrature encoder odometry block.
module tb_quadrature_encoder_odometry;
   timeunit 1ns;
   timeprecision 1ps;

   import qeo_pkg::*;

   localparam int CLK_PERIOD    = 12;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 240;     // one full update plus margin
   localparam int LONG_HOLD     = 1500;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 187;
   localparam int TAPS          = FILTER_TAPS_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam longint unsigned STARTUP_LIMIT_US = 64'd500000;
   localparam longint unsigned VEL_CLAMP        = 64'd2147483647;
   localparam longint signed   POS_HI           = 64'sd2147483647;
   localparam longint signed   POS_LO           = -64'sd2147483648;

   typedef struct {
      logic [15:0] reload;
      logic [9:0]  gear;
      logic [11:0] ppr;
      logic [15:0] radius;
      logic [15:0] tick_us;
      logic [1:0]  unit;
      logic        invert;
   } odo_settings_t;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e            kind;
      logic [1:0]           op;
      logic [15:0]          value;
      logic [CSR_IDX_W-1:0] index;
      int                   reps;
      bit                   typed;
      rsp_type              result;
   } stim_row_t;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int req_idle_pct = 22;
   int rsp_idle_pct = 84;
   bit want_hold    = 1'b0;
   int hold_left    = 0;
   int mismatch_count = 0;

   // Odometry model: settings copy and tracking state
   odo_settings_t      model_cfg;
   logic [31:0]        trk_ticks, trk_last_tick, trk_last_ext;
   logic [15:0]        trk_wraps;
   logic signed [31:0] trk_pos;
   logic signed [31:0] trk_vel_hist [TAPS];

   rsp_type   expected_odometry_q [$];
   stim_row_t stim_table [$];

   quadrature_encoder_odometry u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic odo_settings_t make_settings(
      input logic [15:0] reload, input logic [9:0] gear, input logic [11:0] ppr,
      input logic [15:0] radius, input logic [15:0] tick_us, input logic [1:0] unit,
      input logic invert);
      odo_settings_t s;
      s.reload  = reload;
      s.gear    = gear;
      s.ppr     = ppr;
      s.radius  = radius;
      s.tick_us = tick_us;
      s.unit    = unit;
      s.invert  = invert;
      return s;
   endfunction

   // Q16.16 step for a count magnitude in the selected unit
   function automatic longint unsigned scaled_step(input longint unsigned mag);
      longint unsigned gear, ppr, den, prod, den_mm, whole, frac, mm;
      gear = (model_cfg.gear == '0) ? 64'd1 : 64'(model_cfg.gear);
      ppr  = (model_cfg.ppr == '0) ? 64'd1 : 64'(model_cfg.ppr);
      den  = gear * ppr;
      case (model_cfg.unit)
         UNIT_RAD: return (mag * 64'(PI_HALF_Q24)) / (den << 8);
         UNIT_DEG: return (mag * 64'(DEG_SCALE)) / den;
         default: begin
            // split the scale so the product stays inside 64 bits
            prod   = mag * 64'(model_cfg.radius);
            den_mm = den << 16;
            whole  = prod / den_mm;
            frac   = ((prod % den_mm) * 64'(PI_HALF_Q24)) / den_mm;
            mm     = whole * 64'(PI_HALF_Q24) + frac;
            return (model_cfg.unit == UNIT_MM) ? mm : mm / 64'(MM_PER_M);
         end
      endcase
   endfunction

   // Step per second, built digit group by digit group, clamped to Q16.16 max
   function automatic longint unsigned speed_magnitude(input longint unsigned step,
                                                       input longint unsigned span_us);
      longint unsigned whole, rem, milli, rem2, micro, v;
      if (span_us == 0) return 64'd0;
      whole = step / span_us;
      if (whole > 64'd2147) return VEL_CLAMP;
      rem   = step % span_us;
      milli = (rem * 64'd1000) / span_us;
      rem2  = (rem * 64'd1000) % span_us;
      micro = (rem2 * 64'd1000) / span_us;
      v     = whole * 64'(USEC_PER_SEC) + milli * 64'd1000 + micro;
      return (v > VEL_CLAMP) ? VEL_CLAMP : v;
   endfunction

   task automatic reset_odometry_model();
      model_cfg     = make_settings(16'd65535, 10'd30, 12'd13, 16'd8448, 16'd1000,
                                    UNIT_RAD, 1'b0);
      trk_ticks     = '0;
      trk_last_tick = '0;
      trk_last_ext  = '0;
      trk_wraps     = '0;
      trk_pos       = '0;
      foreach (trk_vel_hist[i]) trk_vel_hist[i] = '0;
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [15:0] value);
      case (index)
         REG_COUNTER_RELOAD: model_cfg.reload  = value;
         REG_GEAR_RATIO:     model_cfg.gear    = value[9:0];
         REG_PULSES_PER_REV: model_cfg.ppr     = value[11:0];
         REG_RADIUS_MM_Q8:   model_cfg.radius  = value;
         REG_TICK_PERIOD_US: model_cfg.tick_us = value;
         REG_UNIT_MODE:      model_cfg.unit    = value[1:0];
         REG_INVERT_COUNT:   model_cfg.invert  = value[0];
         default: ;
      endcase
   endtask

   // Advance the odometry state by one beat; updates yield a result
   task automatic advance_odometry(input req_type item, output bit produced,
                                   output rsp_type res);
      logic signed [15:0] wraps_s;
      longint signed      ext_wide, pos_wide, vel_raw, vel_sum;
      logic [31:0]        ext, delta, neg_delta, elapsed_ticks;
      longint unsigned    mag, step, elapsed_us;
      bit                 forward, negative;
      produced = 1'b0;
      res      = '0;
      case (item.op)
         OP_TICK: trk_ticks = trk_ticks + 32'd1;
         OP_WRAP: begin
            // high counter means the timer wrapped downward
            if ((32'(item.counter_value) << 1) > 32'(model_cfg.reload))
               trk_wraps = trk_wraps - 16'd1;
            else
               trk_wraps = trk_wraps + 16'd1;
            // ignore wraps during startup
            if (64'(trk_ticks) * 64'(model_cfg.tick_us) <= STARTUP_LIMIT_US)
               trk_wraps = '0;
         end
         OP_UPDATE: begin
            wraps_s  = trk_wraps;
            ext_wide = longint'(item.counter_value)
                     + longint'(wraps_s) * longint'(model_cfg.reload);
            ext       = ext_wide[31:0];
            delta     = ext - trk_last_ext;
            forward   = (delta != '0) && !delta[31];
            negative  = forward != model_cfg.invert;
            neg_delta = -delta;
            mag       = delta[31] ? 64'(neg_delta) : 64'(delta);
            step      = scaled_step(mag);

            // saturating position
            pos_wide = negative ? longint'(trk_pos) - longint'(step)
                                : longint'(trk_pos) + longint'(step);
            if (pos_wide > POS_HI)
               pos_wide = POS_HI;
            else if (pos_wide < POS_LO)
               pos_wide = POS_LO;
            trk_pos = pos_wide[31:0];

            // raw velocity over elapsed time, then the moving average
            elapsed_ticks = trk_ticks - trk_last_tick;
            elapsed_us    = 64'(elapsed_ticks) * 64'(model_cfg.tick_us);
            vel_raw = longint'(speed_magnitude(step, elapsed_us));
            if (negative) vel_raw = -vel_raw;
            vel_sum = vel_raw;
            for (int i = TAPS - 1; i > 0; i--) begin
               trk_vel_hist[i] = trk_vel_hist[i-1];
               vel_sum += trk_vel_hist[i];
            end
            trk_vel_hist[0] = vel_raw[31:0];
            vel_sum = vel_sum / longint'(TAPS);

            trk_last_tick  = trk_ticks;
            trk_last_ext   = ext;
            res.position   = trk_pos;
            res.velocity   = vel_sum[31:0];
            res.direction  = negative;
            produced       = 1'b1;
         end
         default: ;
      endcase
   endtask

   // Offer one beat with random idle cycles ahead; predict on acceptance
   task automatic send_item(input logic [1:0] op, input logic [15:0] value,
                            input bit typed = 1'b0, input rsp_type typed_result = '0);
      req_type item;
      bit      produced;
      rsp_type predicted;
      item.op            = op;
      item.counter_value = value;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_odometry(item, produced, predicted);
      if (produced) expected_odometry_q.push_back(typed ? typed_result : predicted);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(index, value);
   endtask

   task automatic apply_settings(input odo_settings_t s);
      write_reg(REG_COUNTER_RELOAD, s.reload);
      write_reg(REG_GEAR_RATIO, 16'(s.gear));
      write_reg(REG_PULSES_PER_REV, 16'(s.ppr));
      write_reg(REG_RADIUS_MM_Q8, s.radius);
      write_reg(REG_TICK_PERIOD_US, s.tick_us);
      write_reg(REG_UNIT_MODE, 16'(s.unit));
      write_reg(REG_INVERT_COUNT, 16'(s.invert));
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain_results();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (expected_odometry_q.size() != 0);
   endtask

   // Drain, then give a trailing tick or wrap time to finish
   task automatic settle_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void row_item(input logic [1:0] op, input logic [15:0] value,
                                    input int reps = 1);
      stim_row_t r;
      r.kind   = ROW_ITEM;
      r.op     = op;
      r.value  = value;
      r.index  = '0;
      r.reps   = reps;
      r.typed  = 1'b0;
      r.result = '0;
      stim_table.push_back(r);
   endfunction

   function automatic void row_checked(input logic [1:0] op, input logic [15:0] value,
                                       input rsp_type result);
      row_item(op, value);
      stim_table[$].typed  = 1'b1;
      stim_table[$].result = result;
   endfunction

   function automatic void row_csr(input logic [CSR_IDX_W-1:0] index,
                                   input logic [15:0] value);
      row_item(OP_TICK, value, 0);
      stim_table[$].kind  = ROW_CSR;
      stim_table[$].index = index;
   endfunction

   // Random encoder motion: ticks, a wrap when the counter rolls over, then an update.
   // One in four steps is an arbitrary beat instead.
   task automatic run_encoder_phase(input int budget, input bit pause_midway);
      int          count, enc_pos, span, reach, step, n_ticks;
      bit          paused;
      logic [1:0]  op;
      logic [15:0] value;
      count   = 0;
      paused  = 1'b0;
      enc_pos = int'($urandom_range(model_cfg.reload));
      while (count < budget) begin
         if (pause_midway && !paused && count >= budget / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(3) != 0) begin
            n_ticks = ($urandom_range(15) == 0) ? int'($urandom_range(40, 4))
                                                : int'($urandom_range(3));
            repeat (n_ticks) begin
               send_item(OP_TICK, 16'(enc_pos));
               count++;
            end
            span  = int'(model_cfg.reload) + 1;
            reach = span / 2;
            if ($urandom_range(1) == 0 && reach > 64) reach = 64;
            step    = int'($urandom_range(2 * reach)) - reach;
            enc_pos = enc_pos + step;
            if (enc_pos > int'(model_cfg.reload) || enc_pos < 0) begin
               enc_pos = (enc_pos < 0) ? enc_pos + span : enc_pos - span;
               send_item(OP_WRAP, 16'(enc_pos));
               count++;
            end
            send_item(OP_UPDATE, 16'(enc_pos));
            count++;
         end else begin
            op = 2'($urandom_range(3));
            if ($urandom_range(7) == 0)
               value = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
            else
               value = 16'($urandom_range(16'hFFFF));
            send_item(op, value);
            if (op != OP_UNUSED) count++;
         end
      end
   endtask

   // Receiver: random stall, or one long hold when asked
   always @(posedge clock) begin
      if (want_hold && hold_left == 0) begin
         hold_left = LONG_HOLD;
         want_hold = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_odometry_q.size() == 0) begin
            $error("unexpected result: position %0d velocity %0d direction %0d",
                   rsp_data.position, rsp_data.velocity, rsp_data.direction);
            mismatch_count++;
         end else begin
            want = expected_odometry_q.pop_front();
            if (rsp_data.position !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position,
                      rsp_data.position);
               mismatch_count++;
            end
            if (rsp_data.velocity !== want.velocity) begin
               $error("velocity: expected %0d, actual %0d", want.velocity,
                      rsp_data.velocity);
               mismatch_count++;
            end
            if (rsp_data.direction !== want.direction) begin
               $error("direction: expected %0d, actual %0d", want.direction,
                      rsp_data.direction);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      odo_settings_t plan [PHASES];
      bit            csr_open;
      reset_odometry_model();
      plan[0] = model_cfg;
      plan[1] = make_settings(16'd1000, 10'd1, 12'd1, 16'd65535, 16'd20000, UNIT_MM, 1'b1);
      plan[2] = make_settings(16'd1, 10'd1023, 12'd4095, 16'd1, 16'd65535, UNIT_DEG, 1'b0);
      plan[3] = make_settings(16'd4096, 10'd50, 12'd11, 16'd3200, 16'd100, UNIT_M, 1'b1);
      plan[4] = make_settings(16'($urandom_range(65535, 1)), 10'($urandom_range(1023, 1)),
                              12'($urandom_range(4095, 1)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535, 1)), 2'($urandom_range(3)),
                              1'($urandom_range(1)));
      plan[5] = make_settings(16'd65535, 10'd1, 12'd1, 16'd65535, 16'd1, UNIT_DEG, 1'b1);

      // Directed rows under reset settings: no motion and no elapsed time give all zero
      row_checked(OP_UPDATE, 16'h0000, '0);
      row_checked(OP_UPDATE, 16'h0000, '0);
      row_item(OP_TICK, 16'h0000);
      row_item(OP_UPDATE, 16'hFFFF);
      row_item(OP_WRAP, 16'h0000);              // forced to zero during startup
      row_item(OP_UNUSED, 16'hFFFF);
      row_item(OP_UPDATE, 16'h0000);
      // Degrees with zero gear and pulses, long ticks: saturate both ways
      row_csr(REG_UNIT_MODE, 16'(UNIT_DEG));
      row_csr(REG_GEAR_RATIO, 16'd0);
      row_csr(REG_PULSES_PER_REV, 16'd0);
      row_csr(REG_TICK_PERIOD_US, 16'hFFFF);
      row_csr(REG_INVERT_COUNT, 16'd1);
      row_item(OP_TICK, 16'h0000, 7);           // past the startup window
      row_item(OP_WRAP, 16'h0000, 2);
      row_item(OP_UPDATE, 16'hFFFF);
      row_item(OP_WRAP, 16'hFFFF, 3);
      row_item(OP_UPDATE, 16'h0000);
      // Reload of one, widest radius, millimetres
      row_csr(REG_COUNTER_RELOAD, 16'd1);
      row_csr(REG_RADIUS_MM_Q8, 16'hFFFF);
      row_csr(REG_UNIT_MODE, 16'(UNIT_MM));
      row_csr(REG_TICK_PERIOD_US, 16'd1);
      row_csr(REG_INVERT_COUNT, 16'd0);
      row_item(OP_WRAP, 16'h0001);
      row_item(OP_WRAP, 16'h0000);
      row_item(OP_UPDATE, 16'h8000);
      row_item(OP_UPDATE, 16'h0001);
      // Metres with zero radius: no step at all
      row_csr(REG_UNIT_MODE, 16'(UNIT_M));
      row_csr(REG_RADIUS_MM_Q8, 16'd0);
      row_item(OP_UPDATE, 16'hFFFF);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; settle once before each run of writes
      csr_open = 1'b0;
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            if (!csr_open) settle_idle();
            write_reg(stim_table[i].index, stim_table[i].value);
            csr_open = 1'b1;
         end else begin
            csr_open = 1'b0;
            repeat (stim_table[i].reps)
               send_item(stim_table[i].op, stim_table[i].value, stim_table[i].typed,
                         stim_table[i].result);
         end
      end

      // Random phases, one setting each; swap idling after two, drop it after four
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 2) begin
            req_idle_pct = 84;
            rsp_idle_pct = 22;
         end
         if (ph == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         settle_idle();
         apply_settings(plan[ph]);
         if (ph == 4) want_hold = 1'b1;
         run_encoder_phase(PHASE_ITEMS, ph == 5);
      end

      settle_idle();
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #(30_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
